FILE: rtl/cepstral_second_difference_top_macros.svh
// assertion helpers shared by the checker
`ifndef CEPSTRAL_SECOND_DIFFERENCE_TOP_MACROS_SVH
`define CEPSTRAL_SECOND_DIFFERENCE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/csd_pkg.sv
package csd_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int DIFF_BITS     = SAMPLE_BITS + 1;
    localparam int RESULT_BITS   = SAMPLE_BITS + 2;
    localparam int INDEX_BITS    = 4;

    localparam int FL_BITS       = 5;
    localparam int WIN_BITS      = 3;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 2;

    localparam logic [REG_IDX_BITS-1:0] REG_FRAME_LENGTH  = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SHORT_WINDOW  = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_SECOND_WINDOW = 2'd2;

    localparam logic [FL_BITS-1:0]  FRAME_LENGTH_RESET  = 5'd13;
    localparam logic [WIN_BITS-1:0] SHORT_WINDOW_RESET  = 3'd2;
    localparam logic [WIN_BITS-1:0] SECOND_WINDOW_RESET = 3'd1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] coef_value;
        logic                          utterance_start;
    } coef_item_t;

    typedef struct packed {
        logic signed [RESULT_BITS-1:0] dd_value;
        logic [INDEX_BITS-1:0]         coef_index;
        logic                          to_power;
        logic                          frame_end;
    } dd_item_t;

endpackage

FILE: rtl/csd_ram.sv
module csd_ram
#(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 272,
    parameter int ADDR_BITS = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/cepstral_second_difference_top.sv
// channel   | dir | handshake              | payload
// coef      | in  | coef_valid/coef_ready  | coef_item_t (coef_value, utterance_start)
// dd        | out | dd_valid/dd_ready      | dd_item_t (dd_value, coef_index, to_power, frame_end)
// apb       | in  | psel/penable, pready=1 | paddr, pwdata, prdata
//
// one coefficient per cycle unless a stalled result holds stage s1; results register after s1
// the raw history ram and the first-difference ram each give one registered read per
// request, issued on accept and consumed when the item leaves stage s1
// reset clears counters and pointer, loads config defaults; history rams need no clearing pass
// a stalled result holds only the stage behind it; items without a result keep flowing
module cepstral_second_difference_top
    import csd_pkg::*;
#(
    parameter int MAX_COEFS      = 16,
    parameter int MAX_SHORT_WIN  = 4,
    parameter int MAX_SECOND_WIN = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     coef_valid,
    output logic                     coef_ready,
    input  coef_item_t               coef_data,

    output logic                     dd_valid,
    input  logic                     dd_ready,
    output dd_item_t                 dd_data,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int HIST_DEPTH = MAX_COEFS * (2 * (MAX_SHORT_WIN + MAX_SECOND_WIN) + 1);
    localparam int PTR_BITS   = $clog2(HIST_DEPTH);
    localparam int HELD_CAP   = 2 * (MAX_SHORT_WIN + MAX_SECOND_WIN);
    localparam int HELD_BITS  = $clog2(HELD_CAP + 1);
    localparam int CNT_BITS   = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
    localparam int LEN_BITS   = $clog2(MAX_COEFS + 1);
    localparam int D_BITS     = $clog2(MAX_SHORT_WIN + 1);
    localparam int DD_BITS    = $clog2(MAX_SECOND_WIN + 1);

    logic [FL_BITS-1:0]   frame_length_reg, frame_length_next;
    logic [WIN_BITS-1:0]  short_window_reg, short_window_next;
    logic [WIN_BITS-1:0]  second_window_reg, second_window_next;

    logic [PTR_BITS-1:0]  ptr_reg, ptr_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [HELD_BITS-1:0] held_reg, held_next;

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_produce_reg;
    logic                 s1_last_reg;
    logic [CNT_BITS-1:0]  s1_k_reg;
    logic [SAMPLE_BITS-1:0] s1_a_reg;
    logic [PTR_BITS-1:0]  s1_ptr_reg;

    logic                 dd_valid_reg, dd_valid_next;
    dd_item_t             dd_data_reg;

    logic                 cfg_write;
    logic                 coef_accept;
    logic                 s1_advance;
    logic [LEN_BITS-1:0]  len_eff;
    logic [D_BITS-1:0]    d_eff;
    logic [DD_BITS-1:0]   dd_eff;
    logic [CNT_BITS-1:0]  k;
    logic [HELD_BITS-1:0] held_base;
    logic                 last;
    logic                 produce;
    logic [PTR_BITS-1:0]  off_x, off_y;
    logic [PTR_BITS-1:0]  x_rd_addr, y_rd_addr;
    logic [SAMPLE_BITS-1:0] x_rd_data;
    logic [DIFF_BITS-1:0] y_rd_data;
    logic signed [DIFF_BITS-1:0]   y_new;
    logic signed [RESULT_BITS-1:0] result;

    function automatic logic [PTR_BITS-1:0] back_addr(input logic [PTR_BITS-1:0] p,
                                                      input logic [PTR_BITS-1:0] off);
        logic [PTR_BITS:0] sum;
        sum = {1'b0, p} - {1'b0, off};
        if (p < off)
        begin
            sum = sum + (PTR_BITS + 1)'(HIST_DEPTH);
        end
        return sum[PTR_BITS-1:0];
    endfunction

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[REG_IDX_BITS+1:2])
            REG_FRAME_LENGTH:  prdata = CFG_DATA_BITS'(frame_length_reg);
            REG_SHORT_WINDOW:  prdata = CFG_DATA_BITS'(short_window_reg);
            REG_SECOND_WINDOW: prdata = CFG_DATA_BITS'(second_window_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        frame_length_next  = frame_length_reg;
        short_window_next  = short_window_reg;
        second_window_next = second_window_reg;
        if (cfg_write)
        begin
            case (paddr[REG_IDX_BITS+1:2])
                REG_FRAME_LENGTH:  frame_length_next  = pwdata[FL_BITS-1:0];
                REG_SHORT_WINDOW:  short_window_next  = pwdata[WIN_BITS-1:0];
                REG_SECOND_WINDOW: second_window_next = pwdata[WIN_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // clamped settings
    always_comb
    begin
        if (frame_length_reg == '0)
            len_eff = LEN_BITS'(1);
        else if (int'(frame_length_reg) > MAX_COEFS)
            len_eff = LEN_BITS'(MAX_COEFS);
        else
            len_eff = LEN_BITS'(frame_length_reg);

        if (short_window_reg == '0)
            d_eff = D_BITS'(1);
        else if (int'(short_window_reg) > MAX_SHORT_WIN)
            d_eff = D_BITS'(MAX_SHORT_WIN);
        else
            d_eff = D_BITS'(short_window_reg);

        if (second_window_reg == '0)
            dd_eff = DD_BITS'(1);
        else if (int'(second_window_reg) > MAX_SECOND_WIN)
            dd_eff = DD_BITS'(MAX_SECOND_WIN);
        else
            dd_eff = DD_BITS'(second_window_reg);
    end

    // handshake and pipeline control
    assign coef_accept = coef_valid && coef_ready;
    assign s1_advance  = s1_valid_reg && (!s1_produce_reg || !dd_valid_reg || dd_ready);
    assign coef_ready  = !s1_valid_reg || s1_advance;

    // frame position and warm-up
    always_comb
    begin
        held_base = coef_data.utterance_start ? '0 : held_reg;
        if (coef_data.utterance_start || (LEN_BITS'(cnt_reg) >= len_eff))
            k = '0;
        else
            k = cnt_reg;
        last    = (LEN_BITS'(k) == (len_eff - LEN_BITS'(1)));
        produce = int'(held_base) >= 2 * (int'(d_eff) + int'(dd_eff));
    end

    // history read addresses
    assign off_x     = PTR_BITS'(2 * int'(d_eff) * int'(len_eff));
    assign off_y     = PTR_BITS'(2 * int'(dd_eff) * int'(len_eff));
    assign x_rd_addr = back_addr(ptr_reg, off_x);
    assign y_rd_addr = back_addr(ptr_reg, off_y);

    always_comb
    begin
        ptr_next  = ptr_reg;
        cnt_next  = cnt_reg;
        held_next = held_reg;
        if (coef_accept)
        begin
            ptr_next = (int'(ptr_reg) == HIST_DEPTH - 1) ? '0 : ptr_reg + PTR_BITS'(1);
            if (last)
            begin
                cnt_next  = '0;
                held_next = (int'(held_base) < HELD_CAP) ? held_base + HELD_BITS'(1)
                                                         : held_base;
            end
            else
            begin
                cnt_next  = k + CNT_BITS'(1);
                held_next = held_base;
            end
        end
        if (cfg_write)
        begin
            cnt_next  = '0;
            held_next = '0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (coef_accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        dd_valid_next = dd_valid_reg;
        if (s1_advance && s1_produce_reg)
            dd_valid_next = 1'b1;
        else if (dd_valid_reg && dd_ready)
            dd_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg  <= FRAME_LENGTH_RESET;
            short_window_reg  <= SHORT_WINDOW_RESET;
            second_window_reg <= SECOND_WINDOW_RESET;
            ptr_reg           <= '0;
            cnt_reg           <= '0;
            held_reg          <= '0;
            s1_valid_reg      <= 1'b0;
            dd_valid_reg      <= 1'b0;
        end
        else
        begin
            frame_length_reg  <= frame_length_next;
            short_window_reg  <= short_window_next;
            second_window_reg <= second_window_next;
            ptr_reg           <= ptr_next;
            cnt_reg           <= cnt_next;
            held_reg          <= held_next;
            s1_valid_reg      <= s1_valid_next;
            dd_valid_reg      <= dd_valid_next;
        end
    end

    // first difference x[t] - x[t-2d], then difference of two of those
    assign y_new  = {s1_a_reg[SAMPLE_BITS-1], s1_a_reg}
                  - {x_rd_data[SAMPLE_BITS-1], x_rd_data};
    assign result = {y_new[DIFF_BITS-1], y_new}
                  - {y_rd_data[DIFF_BITS-1], y_rd_data};

    always_ff @(posedge clk)
    begin
        if (coef_accept)
        begin
            s1_produce_reg <= produce;
            s1_last_reg    <= last;
            s1_k_reg       <= k;
            s1_a_reg       <= coef_data.coef_value;
            s1_ptr_reg     <= ptr_reg;
        end
        if (s1_advance && s1_produce_reg)
        begin
            dd_data_reg.dd_value   <= result;
            dd_data_reg.coef_index <= INDEX_BITS'(s1_k_reg);
            dd_data_reg.to_power   <= (s1_k_reg == '0);
            dd_data_reg.frame_end  <= s1_last_reg;
        end
    end

    assign dd_valid = dd_valid_reg;
    assign dd_data  = dd_data_reg;

    csd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (HIST_DEPTH)
    ) u_raw_hist (
        .clk     (clk),
        .wr_en   (coef_accept),
        .wr_addr (ptr_reg),
        .wr_data (coef_data.coef_value),
        .rd_en   (coef_accept),
        .rd_addr (x_rd_addr),
        .rd_data (x_rd_data)
    );

    csd_ram #(
        .WIDTH (DIFF_BITS),
        .DEPTH (HIST_DEPTH)
    ) u_diff_hist (
        .clk     (clk),
        .wr_en   (s1_advance),
        .wr_addr (s1_ptr_reg),
        .wr_data (y_new),
        .rd_en   (coef_accept),
        .rd_addr (y_rd_addr),
        .rd_data (y_rd_data)
    );

endmodule

FILE: rtl/csd_checker.sv
`include "cepstral_second_difference_top_macros.svh"

module csd_checker
    import csd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     coef_ready,
    input logic     dd_valid,
    input logic     dd_ready,
    input dd_item_t dd_data
);

    `CSD_ASSERT_NEXT(a_dd_valid_hold, dd_valid && !dd_ready, dd_valid, "dd request dropped")
    `CSD_ASSERT_NEXT(a_dd_data_hold, dd_valid && !dd_ready, $stable(dd_data), "dd payload moved")
    `CSD_ASSERT_NOW(a_power_index, dd_valid && dd_data.to_power, dd_data.coef_index == '0, "power flag off index zero")
    `CSD_ASSERT_NOW(a_stall_cause, !coef_ready, dd_valid && !dd_ready, "input stalled without output backpressure")

endmodule

bind cepstral_second_difference_top csd_checker u_csd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef_ready (coef_ready),
    .dd_valid   (dd_valid),
    .dd_ready   (dd_ready),
    .dd_data    (dd_data)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps

import csd_pkg::*;

localparam int unsigned MAX_COEFS      = 16;
localparam int unsigned MAX_SHORT_WIN  = 4;
localparam int unsigned MAX_SECOND_WIN = 4;
localparam int unsigned HIST_DEPTH     = MAX_COEFS * (2 * (MAX_SHORT_WIN + MAX_SECOND_WIN) + 1);
localparam int unsigned HELD_CAP       = 2 * (MAX_SHORT_WIN + MAX_SECOND_WIN);

function automatic int unsigned clamp_range(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo)
    begin
        return lo;
    end
    if (v > hi)
    begin
        return hi;
    end
    return v;
endfunction

class delta_delta_scoreboard;
    logic [FL_BITS-1:0]             frame_length_q;
    logic [WIN_BITS-1:0]            short_win_q;
    logic [WIN_BITS-1:0]            second_win_q;
    logic signed [SAMPLE_BITS-1:0]  history [HIST_DEPTH];
    int unsigned                    wr_ptr;
    int unsigned                    coef_pos;
    int unsigned                    frames_full;
    dd_item_t                       expected_dd [$];
    int unsigned                    error_count;

    function new();
        frame_length_q = FRAME_LENGTH_RESET;
        short_win_q    = SHORT_WINDOW_RESET;
        second_win_q   = SECOND_WINDOW_RESET;
        foreach (history[i])
        begin
            history[i] = '0;
        end
        wr_ptr      = 0;
        coef_pos    = 0;
        frames_full = 0;
        error_count = 0;
    endfunction

    function void apply_reg_write(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_DATA_BITS-1:0] data);
        logic [REG_IDX_BITS-1:0] idx;
        bit                      hit;
        idx = addr[REG_IDX_BITS+1:2];
        hit = 1'b1;
        case (idx)
            REG_FRAME_LENGTH:  frame_length_q = data[FL_BITS-1:0];
            REG_SHORT_WINDOW:  short_win_q    = data[WIN_BITS-1:0];
            REG_SECOND_WINDOW: second_win_q   = data[WIN_BITS-1:0];
            default:           hit = 1'b0;
        endcase
        if (hit)
        begin
            coef_pos    = 0;
            frames_full = 0;
        end
    endfunction

    function int unsigned back_slot(int unsigned newest, int unsigned back);
        return (newest + HIST_DEPTH - back) % HIST_DEPTH;
    endfunction

    function void note_coef(coef_item_t item);
        int unsigned len, d, dd, k, newest;
        bit          last;
        int          a, b, c, e, r;
        dd_item_t    res;
        len = clamp_range(frame_length_q, 1, MAX_COEFS);
        d   = clamp_range(short_win_q, 1, MAX_SHORT_WIN);
        dd  = clamp_range(second_win_q, 1, MAX_SECOND_WIN);
        if (item.utterance_start)
        begin
            coef_pos    = 0;
            frames_full = 0;
        end
        if (coef_pos >= len)
        begin
            coef_pos = 0;
        end
        k    = coef_pos;
        last = (k == len - 1);
        newest          = wr_ptr;
        history[newest] = item.coef_value;
        wr_ptr          = (newest + 1) % HIST_DEPTH;
        if (frames_full >= 2 * (d + dd))
        begin
            a = history[newest];
            b = history[back_slot(newest, 2 * d * len)];
            c = history[back_slot(newest, 2 * dd * len)];
            e = history[back_slot(newest, 2 * (d + dd) * len)];
            r = (a - b) - (c - e);
            res.dd_value   = r[RESULT_BITS-1:0];
            res.coef_index = k[INDEX_BITS-1:0];
            res.to_power   = (k == 0);
            res.frame_end  = last;
            expected_dd.push_back(res);
        end
        if (last)
        begin
            coef_pos = 0;
            if (frames_full < HELD_CAP)
            begin
                frames_full++;
            end
        end
        else
        begin
            coef_pos = k + 1;
        end
    endfunction

    function void compare_field(string field, logic signed [31:0] want, logic signed [31:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= 40)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        end
    endfunction

    function void check_dd(dd_item_t got);
        dd_item_t want;
        if (expected_dd.size() == 0)
        begin
            error_count++;
            if (error_count <= 40)
            begin
                $display("%0t: unexpected result, expected none, actual dd_value %0d index %0d",
                         $time, got.dd_value, got.coef_index);
            end
            return;
        end
        want = expected_dd.pop_front();
        compare_field("dd_value", want.dd_value, got.dd_value);
        compare_field("coef_index", want.coef_index, got.coef_index);
        compare_field("to_power", want.to_power, got.to_power);
        compare_field("frame_end", want.frame_end, got.frame_end);
    endfunction
endclass

module tb;

    localparam int unsigned ITEMS        = 1800;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned LONG_HOLD    = 300;

    logic                     clk;
    logic                     rst_n;
    logic                     coef_valid;
    logic                     coef_ready;
    coef_item_t               coef_data;
    logic                     dd_valid;
    logic                     dd_ready;
    dd_item_t                 dd_data;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    delta_delta_scoreboard sb;
    bit                    long_hold_pending;

    cepstral_second_difference_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_valid (coef_valid),
        .coef_ready (coef_ready),
        .coef_data  (coef_data),
        .dd_valid   (dd_valid),
        .dd_ready   (dd_ready),
        .dd_data    (dd_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_coef();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return $urandom_range(0, 1) ? 16'sh0000 : 16'shFFFF;
            3:       return SAMPLE_BITS'($urandom_range(0, 15) - 8);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dd_valid && dd_ready)
            begin
                sb.check_dd(dd_data);
            end
            if (coef_valid && coef_ready)
            begin
                sb.note_coef(coef_data);
            end
            if (psel && penable && pwrite && pready)
            begin
                sb.apply_reg_write(paddr, pwdata);
            end
        end
    end

    task automatic send_coef(input coef_item_t item, input int unsigned gap);
        coef_valid <= 1'b1;
        coef_data  <= item;
        do @(posedge clk); while (!coef_ready);
        if (gap > 0)
        begin
            coef_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic program_config(input int unsigned fl, input int unsigned sw, input int unsigned dw);
        logic [REG_IDX_BITS-1:0] regs [3];
        int unsigned             vals [3];
        regs[0] = REG_FRAME_LENGTH;
        regs[1] = REG_SHORT_WINDOW;
        regs[2] = REG_SECOND_WINDOW;
        vals[0] = fl;
        vals[1] = sw;
        vals[2] = dw;
        for (int i = 0; i < 3; i++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {regs[i], 2'b00};
            pwdata  <= ($urandom() & 32'hFFFF_FF00) | vals[i];
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.expected_dd.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // result receiver
    initial
    begin
        int unsigned gap;
        dd_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                dd_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                dd_ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                dd_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    dd_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        int unsigned total, phase, fl, sw, dw, len, d, dd, warm, count;
        bit          tx_steady;
        coef_item_t  item;
        sb = new();
        rst_n      <= 1'b0;
        coef_valid <= 1'b0;
        coef_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extreme second differences with the smallest windows and one-coefficient frames
        program_config(1, 1, 1);
        for (int i = 0; i < 14; i++)
        begin
            item.coef_value      = (i % 4 == 0) ? 16'sh7FFF : (i % 4 == 2) ? 16'sh8000 : 16'sh0000;
            item.utterance_start = (i == 0);
            send_coef(item, pick_gap());
        end
        // utterance restart in the middle of a stream
        for (int i = 0; i < 6; i++)
        begin
            item.coef_value      = (i % 2 == 1) ? 16'sh7FFF : 16'shFFFF;
            item.utterance_start = (i == 0);
            send_coef(item, pick_gap());
        end
        coef_valid <= 1'b0;

        total = 0;
        phase = 0;
        while (total < ITEMS)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    fl = 16; sw = 1; dw = 1;
                end
                1:
                begin
                    fl = 16; sw = 4; dw = 4;
                end
                2:
                begin
                    fl = 1; sw = 4; dw = 4;
                end
                3:
                begin
                    fl = 0; sw = 0; dw = 0;
                end
                4:
                begin
                    fl = 31; sw = 7; dw = 7;
                end
                5:
                begin
                    fl = 13; sw = 2; dw = 1;
                end
                default:
                begin
                    fl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
                    sw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
                    dw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
                end
            endcase
            program_config(fl, sw, dw);
            len   = clamp_range(fl, 1, MAX_COEFS);
            d     = clamp_range(sw, 1, MAX_SHORT_WIN);
            dd    = clamp_range(dw, 1, MAX_SECOND_WIN);
            warm  = 2 * (d + dd) * len + len;
            count = (phase == 0) ? warm + 300 : warm + $urandom_range(40, 160);
            tx_steady = (phase == 0) || ($urandom_range(0, 2) == 0);
            for (int i = 0; i < count; i++)
            begin
                // stall the receiver while requests keep coming
                if (phase == 0 && i == warm)
                begin
                    long_hold_pending = 1'b1;
                end
                item.coef_value      = random_coef();
                item.utterance_start = (i == 0) ? 1'($urandom_range(0, 1))
                                                : ($urandom_range(0, 199) == 0);
                send_coef(item, tx_steady ? 0 : pick_gap());
            end
            coef_valid <= 1'b0;
            total += count;
            phase++;
        end

        wait_drained();
        if (sb.error_count == 0)
        begin
            $display("cepstral_second_difference_top regression: pass");
        end
        else
        begin
            $display("cepstral_second_difference_top regression: fail");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("cepstral_second_difference_top regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/csd_pkg.sv
rtl/csd_ram.sv
rtl/cepstral_second_difference_top.sv
rtl/csd_checker.sv
dv/tb.sv
